>>> sv/gu2x_pkg.sv
// ----------------------------------------------------------------------------
// gu2x_pkg
// Shared constants, types and cell codes for the 2x bilinear grid upsampler.
// ----------------------------------------------------------------------------
package gu2x_pkg;

  localparam int unsigned MAX_SIDE  = 1024;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CNT_W     = $clog2(MAX_SIDE);
  localparam int unsigned COORD_W   = CNT_W + 1;
  localparam int unsigned NUM_CELLS = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [CNT_W-1:0]    cnt_t;
  typedef logic        [COORD_W-1:0]  coord_t;
  typedef logic        [CFG_W-1:0]    side_t;
  typedef logic        [NUM_CELLS-1:0] cell_mask_t;

  // Fine-grid cells produced by one sample, in output order
  typedef enum logic [1:0] {
    CELL_MAIN   = 2'd0,
    CELL_EDGE   = 2'd1,
    CELL_BOTTOM = 2'd2,
    CELL_CORNER = 2'd3
  } cell_t;

  // Everything the output sequencer needs for one input sample
  typedef struct packed {
    sample_t    ul;
    sample_t    up;
    sample_t    lf;
    sample_t    cur;
    cnt_t       col;
    cnt_t       row;
    cell_mask_t mask;
  } gu2x_job_t;

endpackage

>>> sv/gu2x_ram.sv
// ----------------------------------------------------------------------------
// gu2x_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gu2x_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/gu2x_emit.sv
// ----------------------------------------------------------------------------
// gu2x_emit
// Output sequencer: walks the cells of one sample, one fine point per beat,
// and computes copies and floor averages into the output register.
// ----------------------------------------------------------------------------
module gu2x_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_load,
  input  gu2x_pkg::gu2x_job_t job_in,
  output logic                job_free,
  input  logic                out_ready,
  output logic                out_valid,
  output gu2x_pkg::sample_t   out_value,
  output gu2x_pkg::coord_t    out_col,
  output gu2x_pkg::coord_t    out_row,
  output logic                out_run_last,
  output logic                out_grid_done
);
  import gu2x_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + 2;

  gu2x_job_t  job_r, job_nxt;
  logic       job_valid_r, job_valid_nxt;
  cell_mask_t mask_r, mask_nxt;
  logic [1:0] q_r, q_nxt;

  logic       out_valid_r, out_valid_nxt;
  sample_t    out_value_r;
  coord_t     out_col_r, out_row_r;
  logic       out_run_last_r, out_grid_done_r;

  cell_t      g;
  cell_mask_t mask_left;
  logic       step, last, finish;
  sample_t    op0, op1, op2, op3;
  logic [1:0] sh;
  logic signed [SUM_W-1:0] sum, shifted;
  cnt_t       ci, cj;

  always_comb begin
    if (mask_r[CELL_MAIN]) begin
      g = CELL_MAIN;
    end else if (mask_r[CELL_EDGE]) begin
      g = CELL_EDGE;
    end else if (mask_r[CELL_BOTTOM]) begin
      g = CELL_BOTTOM;
    end else begin
      g = CELL_CORNER;
    end
  end

  assign mask_left = mask_r & ~(NUM_CELLS'(1) << g);
  assign step      = job_valid_r && (!out_valid_r || out_ready);
  assign last      = (q_r == 2'd3) && (mask_left == '0);
  assign finish    = step && last;
  assign job_free  = !job_valid_r || finish;

  // operand selection per cell and sub-point
  always_comb begin
    op0 = '0;
    op1 = '0;
    op2 = '0;
    op3 = '0;
    sh  = 2'd0;
    case (g)
      CELL_MAIN: begin
        op0 = job_r.ul;
        case (q_r)
          2'd1: begin
            op1 = job_r.up;
            sh  = 2'd1;
          end
          2'd2: begin
            op1 = job_r.lf;
            sh  = 2'd1;
          end
          2'd3: begin
            op1 = job_r.up;
            op2 = job_r.lf;
            op3 = job_r.cur;
            sh  = 2'd2;
          end
          default: ;
        endcase
      end
      CELL_EDGE: begin
        op0 = job_r.up;
        if (q_r[1]) begin
          op1 = job_r.cur;
          sh  = 2'd1;
        end
      end
      CELL_BOTTOM: begin
        op0 = job_r.lf;
        if (q_r == 2'd1) begin
          op1 = job_r.cur;
          sh  = 2'd1;
        end
      end
      default: begin
        op0 = job_r.cur;
      end
    endcase
  end

  assign sum     = SUM_W'(op0) + SUM_W'(op1) + SUM_W'(op2) + SUM_W'(op3);
  assign shifted = sum >>> sh;

  assign ci = (g inside {CELL_MAIN, CELL_BOTTOM}) ? job_r.col - cnt_t'(1) : job_r.col;
  assign cj = (g inside {CELL_MAIN, CELL_EDGE})   ? job_r.row - cnt_t'(1) : job_r.row;

  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    mask_nxt      = mask_r;
    q_nxt         = q_r;
    if (job_load) begin
      job_nxt       = job_in;
      job_valid_nxt = 1'b1;
      mask_nxt      = job_in.mask;
      q_nxt         = 2'd0;
    end else if (finish) begin
      job_valid_nxt = 1'b0;
    end else if (step) begin
      q_nxt = q_r + 2'd1;
      if (q_r == 2'd3) begin
        mask_nxt = mask_left;
      end
    end
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      q_r         <= 2'd0;
      mask_r      <= '0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      q_r         <= q_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (step) begin
      out_value_r     <= shifted[SAMPLE_W-1:0];
      out_col_r       <= {ci, q_r[0]};
      out_row_r       <= {cj, q_r[1]};
      out_run_last_r  <= last;
      out_grid_done_r <= last && (g == CELL_CORNER);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_col       = out_col_r;
  assign out_row       = out_row_r;
  assign out_run_last  = out_run_last_r;
  assign out_grid_done = out_grid_done_r;

endmodule

>>> sv/grid_upsample_2x_bilinear_core.sv
// ----------------------------------------------------------------------------
// grid_upsample_2x_bilinear_core
// 2x bilinear upsampler for square grids of signed Q16.16 samples.
//
// Usage:
//   Samples enter row-major on the in_ channel (valid/ready). Each fine point
//   leaves on the out_ channel with its doubled-grid column and row; run_last
//   marks the last point of an input beat, grid_done the last point of the
//   grid. Sample (r,c) releases coarse cell (r-1,c-1) plus edge cells on the
//   last column/row: 0, 4, 8 or 16 points, 4 on average.
//   cfg_wr_en/cfg_wr_data set the grid side (clamped to 2..1024); write it
//   only while the block is idle.
//   A beat passes the capture stage, then the job and output registers.
//   Throughput: one point per cycle while out_ready is high, set by the
//   output sequencer; a beat holds it until its last point is emitted, and
//   beats with no points pass at one per cycle while the sequencer is free.
//   The line buffer is a 1024x32 RAM read once and written once per beat.
//   Reset: position counters clear, side returns to 1024; the line buffer is
//   not cleared (row 0 fills it before any of it is used).
//   A stalled receiver holds the output register; the input side keeps
//   taking beats until the sequencer and the capture stage are both full.
// ----------------------------------------------------------------------------
module grid_upsample_2x_bilinear_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  gu2x_pkg::side_t     cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  gu2x_pkg::sample_t   in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output gu2x_pkg::sample_t   out_value,
  output gu2x_pkg::coord_t    out_col,
  output gu2x_pkg::coord_t    out_row,
  output logic                out_run_last,
  output logic                out_grid_done
);
  import gu2x_pkg::*;

  side_t      side_r, side_nxt;
  side_t      side_eff;
  cnt_t       side_m1;
  cnt_t       col_cnt_r, col_cnt_nxt;
  cnt_t       row_cnt_r, row_cnt_nxt;
  logic       restart;
  cnt_t       c, r;
  logic       at_last_col, at_last_row;
  cell_mask_t mask;
  logic       in_acc;

  logic       s1_valid_r, s1_valid_nxt;
  sample_t    s1_cur_r;
  cnt_t       s1_col_r, s1_row_r;
  cell_mask_t s1_mask_r;
  logic       s1_go;

  sample_t    prev_up_r, prev_cur_r;
  sample_t    ram_rd;
  gu2x_job_t  job;
  logic       job_load, job_free;

  // configuration
  always_comb begin
    side_nxt = cfg_wr_en ? cfg_wr_data : side_r;
  end

  always_comb begin
    if (side_r < side_t'(2)) begin
      side_eff = side_t'(2);
    end else if (side_r > side_t'(MAX_SIDE)) begin
      side_eff = side_t'(MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  assign side_m1 = CNT_W'(side_eff - side_t'(1));

  // position of the incoming beat
  assign restart     = (side_t'(col_cnt_r) >= side_eff) || (side_t'(row_cnt_r) >= side_eff);
  assign c           = restart ? '0 : col_cnt_r;
  assign r           = restart ? '0 : row_cnt_r;
  assign at_last_col = (c == side_m1);
  assign at_last_row = (r == side_m1);

  always_comb begin
    mask              = '0;
    mask[CELL_MAIN]   = (r != '0) && (c != '0);
    mask[CELL_EDGE]   = (r != '0) && at_last_col;
    mask[CELL_BOTTOM] = at_last_row && (c != '0);
    mask[CELL_CORNER] = at_last_row && at_last_col;
  end

  assign s1_go    = s1_valid_r && job_free;
  assign in_ready = !s1_valid_r || job_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (at_last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = at_last_row ? '0 : r + cnt_t'(1);
      end else begin
        col_cnt_nxt = c + cnt_t'(1);
        row_cnt_nxt = r;
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= side_t'(MAX_SIDE);
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      side_r     <= side_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r  <= in_sample;
      s1_col_r  <= c;
      s1_row_r  <= r;
      s1_mask_r <= mask;
    end
    if (s1_go) begin
      prev_up_r  <= ram_rd;
      prev_cur_r <= s1_cur_r;
    end
  end

  // line buffer: read at acceptance, written back when the beat moves on
  gu2x_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SIDE)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (s1_cur_r),
    .rd_en   (in_acc),
    .rd_addr (c),
    .rd_data (ram_rd)
  );

  always_comb begin
    job.ul   = prev_up_r;
    job.up   = ram_rd;
    job.lf   = prev_cur_r;
    job.cur  = s1_cur_r;
    job.col  = s1_col_r;
    job.row  = s1_row_r;
    job.mask = s1_mask_r;
  end

  assign job_load = s1_go && (s1_mask_r != '0);

  gu2x_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_load      (job_load),
    .job_in        (job),
    .job_free      (job_free),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_run_last  (out_run_last),
    .out_grid_done (out_grid_done)
  );

  // read and write-back of the line buffer never hit the same entry together
  a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_go && s1_valid_r) |-> (c != s1_col_r))
    else $error("line buffer read and write collide");

  a_done_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_grid_done) |-> (out_run_last && out_col == out_row && out_col[0]))
    else $error("grid_done on a point other than the far corner");

  a_first_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_col[0] && !out_row[0]) |-> !out_run_last)
    else $error("run_last on the first point of a cell");

endmodule
